// ===== design/uhg_pkg.sv =====
// Package for the upload health guard: payload types, verdict and register codes.
// Reset values of the configuration registers. No dependencies.
package uhg_pkg;

    localparam int UHG_COUNT_WIDTH = 32;
    localparam int UHG_TOTAL_WIDTH = 32;
    localparam int UHG_GRACE_WIDTH = 16;
    localparam int UHG_FAIL_WIDTH  = 16;
    localparam int UHG_LIMIT_WIDTH = 32;
    localparam int UHG_CFG_WIDTH   = 32;
    localparam int UHG_INDEX_WIDTH = 2;

    localparam logic [UHG_GRACE_WIDTH-1:0] UHG_GRACE_RESET     = 16'd5;
    localparam logic [UHG_FAIL_WIDTH-1:0]  UHG_MAX_FAIL_RESET  = 16'd3;
    localparam logic [UHG_LIMIT_WIDTH-1:0] UHG_MAX_DROP_RESET  = 32'd50;

    typedef enum logic [1:0] {
        VERDICT_CONTINUE = 2'd0,
        VERDICT_LOST     = 2'd1,
        VERDICT_SENDFAIL = 2'd2,
        VERDICT_OVERRUN  = 2'd3
    } verdict_t;

    typedef enum logic [UHG_INDEX_WIDTH-1:0] {
        CFG_GRACE_OBSERVATIONS = 2'd0,
        CFG_MAX_SEND_FAILURES  = 2'd1,
        CFG_MAX_DROPPED_FRAMES = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_OBSERVE = 1'b0,
        CMD_RESTART = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                       cmd;
        logic                       link_up;
        logic                       send_ok;
        logic [UHG_TOTAL_WIDTH-1:0] dropped_total;
    } obs_item_t;

    typedef struct packed {
        verdict_t verdict;
    } result_item_t;

    typedef struct packed {
        logic [UHG_INDEX_WIDTH-1:0] index;
        logic [UHG_CFG_WIDTH-1:0]   data;
    } cfg_item_t;

endpackage

// ===== design/uhg_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
// Payload type is a parameter; used with the types of uhg_pkg.
interface uhg_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ===== design/upload_health_guard.sv =====
// Upload health guard top level: configuration registers, state and result register.
// Depends on uhg_pkg, uhg_chan_if and uhg_update.
// A verdict is registered and valid the cycle after its observe transaction is accepted.
// Throughput: one transaction per cycle; the result register stalls input only
// while it holds a verdict that the sink is not ready to take.
// Reset: rst_n clears all counters and the baseline and loads the register defaults.
module upload_health_guard
    import uhg_pkg::*;
#(
    parameter int COUNT_WIDTH = UHG_COUNT_WIDTH
) (
    input  logic  clk,
    input  logic  rst_n,
    uhg_chan_if.sink   observe,
    uhg_chan_if.source result,
    uhg_chan_if.sink   cfg
);

    logic [UHG_GRACE_WIDTH-1:0] grace_reg;
    logic [UHG_FAIL_WIDTH-1:0]  max_fail_reg;
    logic [UHG_LIMIT_WIDTH-1:0] max_drop_reg;

    logic [UHG_TOTAL_WIDTH-1:0] baseline_reg;
    logic [COUNT_WIDTH-1:0]     obs_count_reg;
    logic [COUNT_WIDTH-1:0]     drop_sum_reg;
    logic [COUNT_WIDTH-1:0]     fail_run_reg;

    logic [UHG_TOTAL_WIDTH-1:0] baseline_next;
    logic [COUNT_WIDTH-1:0]     obs_count_next;
    logic [COUNT_WIDTH-1:0]     drop_sum_next;
    logic [COUNT_WIDTH-1:0]     fail_run_next;
    verdict_t                   verdict_next;

    logic                       out_valid_reg;
    result_item_t               out_data_reg;
    logic                       accept;
    obs_item_t                  obs_item;
    cfg_item_t                  cfg_item;

    assign obs_item      = observe.data;
    assign cfg_item      = cfg.data;
    assign observe.ready = !out_valid_reg || result.ready;
    assign accept        = observe.valid && observe.ready;
    assign cfg.ready     = 1'b1;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_data_reg;

    uhg_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .item           (obs_item),
        .grace          (grace_reg),
        .max_fail       (max_fail_reg),
        .max_drop       (max_drop_reg),
        .baseline       (baseline_reg),
        .obs_count      (obs_count_reg),
        .drop_sum       (drop_sum_reg),
        .fail_run       (fail_run_reg),
        .baseline_next  (baseline_next),
        .obs_count_next (obs_count_next),
        .drop_sum_next  (drop_sum_next),
        .fail_run_next  (fail_run_next),
        .verdict        (verdict_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg    <= UHG_GRACE_RESET;
            max_fail_reg <= UHG_MAX_FAIL_RESET;
            max_drop_reg <= UHG_MAX_DROP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_item.index)
                CFG_GRACE_OBSERVATIONS: grace_reg    <= cfg_item.data[UHG_GRACE_WIDTH-1:0];
                CFG_MAX_SEND_FAILURES:  max_fail_reg <= cfg_item.data[UHG_FAIL_WIDTH-1:0];
                CFG_MAX_DROPPED_FRAMES: max_drop_reg <= cfg_item.data[UHG_LIMIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            obs_count_reg <= '0;
            drop_sum_reg  <= '0;
            fail_run_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                baseline_reg  <= baseline_next;
                obs_count_reg <= obs_count_next;
                drop_sum_reg  <= drop_sum_next;
                fail_run_reg  <= fail_run_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.verdict <= verdict_next;
        end
    end

endmodule

// ===== design/uhg_update.sv =====
// Next-state and verdict logic of the upload health guard for one transaction.
// Depends on uhg_pkg.
module uhg_update
    import uhg_pkg::*;
#(
    parameter int COUNT_WIDTH = UHG_COUNT_WIDTH
) (
    input  obs_item_t                   item,
    input  logic [UHG_GRACE_WIDTH-1:0]  grace,
    input  logic [UHG_FAIL_WIDTH-1:0]   max_fail,
    input  logic [UHG_LIMIT_WIDTH-1:0]  max_drop,
    input  logic [UHG_TOTAL_WIDTH-1:0]  baseline,
    input  logic [COUNT_WIDTH-1:0]      obs_count,
    input  logic [COUNT_WIDTH-1:0]      drop_sum,
    input  logic [COUNT_WIDTH-1:0]      fail_run,
    output logic [UHG_TOTAL_WIDTH-1:0]  baseline_next,
    output logic [COUNT_WIDTH-1:0]      obs_count_next,
    output logic [COUNT_WIDTH-1:0]      drop_sum_next,
    output logic [COUNT_WIDTH-1:0]      fail_run_next,
    output verdict_t                    verdict
);

    localparam int ExtWidth = ((COUNT_WIDTH > UHG_TOTAL_WIDTH) ? COUNT_WIDTH
                                                               : UHG_TOTAL_WIDTH) + 1;
    localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

    logic [UHG_TOTAL_WIDTH-1:0] rise;
    logic [COUNT_WIDTH-1:0]     obs_inc;
    logic [COUNT_WIDTH-1:0]     fail_inc;
    logic [ExtWidth-1:0]        sum_ext;
    logic [COUNT_WIDTH-1:0]     sum_sat;
    logic [COUNT_WIDTH-1:0]     drop_upd;
    logic [COUNT_WIDTH-1:0]     fail_upd;
    logic                       past_grace;
    logic                       fail_hit;
    logic                       drop_hit;

    always_comb
    begin
        rise = (item.dropped_total >= baseline) ? (item.dropped_total - baseline)
                                                : '0;
        obs_inc  = (obs_count == CountMax) ? obs_count : obs_count + 1'b1;
        fail_inc = (fail_run == CountMax) ? fail_run : fail_run + 1'b1;

        sum_ext = ExtWidth'(drop_sum) + ExtWidth'(rise);
        sum_sat = (sum_ext > ExtWidth'(CountMax)) ? CountMax : sum_ext[COUNT_WIDTH-1:0];

        past_grace = ExtWidth'(obs_inc) > ExtWidth'(grace);
        drop_upd   = past_grace ? sum_sat : drop_sum;
        fail_upd   = item.send_ok ? '0 : fail_inc;

        fail_hit = ExtWidth'(fail_upd) >= ExtWidth'(max_fail);
        drop_hit = ExtWidth'(drop_upd) >= ExtWidth'(max_drop);

        if (item.cmd == CMD_RESTART)
        begin
            baseline_next  = item.dropped_total;
            obs_count_next = '0;
            drop_sum_next  = '0;
            fail_run_next  = '0;
            verdict        = VERDICT_CONTINUE;
        end
        else if (!item.link_up)
        begin
            baseline_next  = baseline;
            obs_count_next = obs_count;
            drop_sum_next  = drop_sum;
            fail_run_next  = fail_run;
            verdict        = VERDICT_LOST;
        end
        else
        begin
            baseline_next  = item.dropped_total;
            obs_count_next = obs_inc;
            drop_sum_next  = drop_upd;
            fail_run_next  = fail_upd;
            if (fail_hit)
            begin
                verdict = VERDICT_SENDFAIL;
            end
            else if (drop_hit)
            begin
                verdict = VERDICT_OVERRUN;
            end
            else
            begin
                verdict = VERDICT_CONTINUE;
            end
        end
    end

endmodule
